// ===== rtl/core/sasi_initiator_sector_sequencer_assert.svh =====
// Assertion macros for the SASI initiator sector sequencer.
// Depends on nothing; included inside the sequencer module body, which checks itself.
`ifndef SASI_INITIATOR_SECTOR_SEQUENCER_ASSERT_SVH
`define SASI_INITIATOR_SECTOR_SEQUENCER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SISS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define SISS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/siss_pkg.sv =====
// Types and constants for the SASI initiator sector sequencer.
// Depends on nothing; imported by the sequencer and by the testbench.
package siss_pkg;

    typedef enum logic [3:0] {
        S_IDLE, S_RST_HOLD, S_RST_GAP, S_BUSY_CLR, S_SETTLE, S_BUSY_SET,
        S_SEL_REQ, S_CDB_REQ, S_CDB_DROP, S_DIN_PHASE, S_DIN_REQ,
        S_DOUT_PHASE, S_DOUT_REQ, S_DOUT_DROP, S_STATUS, S_MESSAGE
    } step_t;

    localparam logic [1:0] OP_POLL   = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_LOAD   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] CMD_INIT  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_SENSE = 2'd3;

    localparam logic [2:0] K_DATA  = 3'd0;
    localparam logic [2:0] K_CTRL  = 3'd1;
    localparam logic [2:0] K_SECT  = 3'd2;
    localparam logic [2:0] K_SENSE = 3'd3;
    localparam logic [2:0] K_DONE  = 3'd4;

    localparam logic [2:0] E_OK    = 3'd0;
    localparam logic [2:0] E_INVAL = 3'd1;
    localparam logic [2:0] E_TIME  = 3'd2;
    localparam logic [2:0] E_IO    = 3'd3;
    localparam logic [2:0] E_RO    = 3'd4;
    localparam logic [2:0] E_NODEV = 3'd5;

    localparam logic [1:0] ACT_RELEASE = 2'd0;
    localparam logic [1:0] ACT_SELECT  = 2'd1;
    localparam logic [1:0] ACT_RESET   = 2'd2;

    localparam logic [2:0] AC_TUR   = 3'd0;
    localparam logic [2:0] AC_RAM   = 3'd1;
    localparam logic [2:0] AC_CTL   = 3'd2;
    localparam logic [2:0] AC_SENSE = 3'd3;
    localparam logic [2:0] AC_READ  = 3'd4;
    localparam logic [2:0] AC_WRITE = 3'd5;

    localparam logic [2:0] REG_TARGET   = 3'd0;
    localparam logic [2:0] REG_WREN     = 3'd1;
    localparam logic [2:0] REG_SEL_TMO  = 3'd2;
    localparam logic [2:0] REG_PH_TMO   = 3'd3;
    localparam logic [2:0] REG_LONG_TMO = 3'd4;
    localparam logic [2:0] REG_DROP     = 3'd5;
    localparam logic [2:0] REG_RST_HOLD = 3'd6;
    localparam logic [2:0] REG_SETTLE   = 3'd7;

    localparam logic [31:0] LBA_LIMIT = 32'h001F_FFFF;

    typedef struct packed {
        logic [1:0]  operation;
        logic [1:0]  command;
        logic [31:0] block_address;
        logic [7:0]  load_byte;
        logic [8:0]  load_index;
        logic        bus_busy;
        logic        bus_req;
        logic        bus_control;
        logic        bus_input;
        logic        bus_msg;
        logic [7:0]  bus_data;
    } in_t;

    typedef struct packed {
        logic [2:0] result_kind;
        logic [7:0] bus_value;
        logic [1:0] control_action;
        logic [8:0] byte_index;
        logic       last_of_run;
        logic [2:0] error_code;
        logic [7:0] cmd_status;
        logic [7:0] cmd_message;
        logic       device_ready;
    } out_t;

    function automatic out_t mk(logic [2:0] k, logic [7:0] v, logic [1:0] a,
                                logic [8:0] i, logic [2:0] e, logic [7:0] st,
                                logic [7:0] msg);
        out_t r;
        r.result_kind    = k;
        r.bus_value      = v;
        r.control_action = a;
        r.byte_index     = i;
        r.last_of_run    = 1'b0;
        r.error_code     = e;
        r.cmd_status     = st;
        r.cmd_message    = msg;
        r.device_ready   = 1'b0;
        return r;
    endfunction

    function automatic logic [7:0] cdb_byte(logic [2:0] ac, logic [20:0] lba,
                                            logic [2:0] i);
        logic [7:0] b;
        b = 8'h00;
        if (i == 3'd0) begin
            unique case (ac)
                AC_TUR:   b = 8'h00;
                AC_RAM:   b = 8'hE0;
                AC_CTL:   b = 8'hE4;
                AC_SENSE: b = 8'h03;
                AC_READ:  b = 8'h08;
                AC_WRITE: b = 8'h0A;
                default:  b = 8'h00;
            endcase
        end else if (ac == AC_READ || ac == AC_WRITE) begin
            unique case (i)
                3'd1:    b = {3'b000, lba[20:16]};
                3'd2:    b = lba[15:8];
                3'd3:    b = lba[7:0];
                3'd4:    b = 8'h01;
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

endpackage

// ===== rtl/core/sasi_initiator_sector_sequencer.sv =====
// SASI initiator sector sequencer: command sequencing, sector store and result queue.
// Depends on siss_pkg and sasi_initiator_sector_sequencer_assert.svh.

// Every transaction on the input channel is judged in the cycle it is accepted, one per
// cycle while s_ready is high, and gives up to two results that enter a four-entry result
// queue. Input is accepted while the queue holds at most one result, so items flow at one
// per clock while the output side keeps up with single results; items that give several
// results cost one output cycle per result. Write data is read from the sector store ahead of use.
module sasi_initiator_sector_sequencer #(
    parameter int SECTOR_BYTES = 512
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  siss_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output siss_pkg::out_t  m_data,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [4:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    import siss_pkg::*;

    localparam int AW  = $clog2(SECTOR_BYTES);
    localparam int BCW = $clog2(SECTOR_BYTES + 1);

    logic [2:0]  target_reg;
    logic        wren_reg;
    logic [15:0] sel_tmo_reg, ph_tmo_reg, rst_hold_reg;
    logic [23:0] long_tmo_reg;
    logic [7:0]  drop_reg, settle_reg;

    step_t          step_reg, step_next;
    logic [23:0]    pc_reg, pc_next, pc_inc;
    logic [BCW-1:0] bc_reg, bc_next, bc_inc;
    logic [2:0]     ac_reg, ac_next;
    logic [2:0]     init_reg, init_next;
    logic [20:0]    lba_reg, lba_next;
    logic [7:0]     cap_reg, cap_next;
    logic           dev_reg, dev_next;

    logic [7:0]  store [SECTOR_BYTES];
    logic [7:0]  rdata_reg;
    logic        we;
    logic [AW-1:0] waddr, raddr;

    out_t        res_c [3];
    out_t        res_f [3];
    logic [1:0]  nres_c;
    logic        fail_c;
    logic [2:0]  fail_err;
    logic [7:0]  fail_msg;

    out_t        fifo_reg [4];
    logic [1:0]  wp_reg, rp_reg;
    logic [2:0]  cnt_reg;
    logic        acc, pop;
    logic        busy;
    logic [3:0]  q;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg   <= 3'd0;
            wren_reg     <= 1'b0;
            sel_tmo_reg  <= 16'd1000;
            ph_tmo_reg   <= 16'd10000;
            long_tmo_reg <= 24'd16776960;
            drop_reg     <= 8'd100;
            rst_hold_reg <= 16'd10000;
            settle_reg   <= 8'd10;
        end else if (cfg_we) begin
            unique case (paddr[4:2])
                REG_TARGET:   target_reg   <= pwdata[2:0];
                REG_WREN:     wren_reg     <= pwdata[0];
                REG_SEL_TMO:  sel_tmo_reg  <= pwdata[15:0];
                REG_PH_TMO:   ph_tmo_reg   <= pwdata[15:0];
                REG_LONG_TMO: long_tmo_reg <= pwdata[23:0];
                REG_DROP:     drop_reg     <= pwdata[7:0];
                REG_RST_HOLD: rst_hold_reg <= pwdata[15:0];
                REG_SETTLE:   settle_reg   <= pwdata[7:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_TARGET:   prdata = {29'd0, target_reg};
            REG_WREN:     prdata = {31'd0, wren_reg};
            REG_SEL_TMO:  prdata = {16'd0, sel_tmo_reg};
            REG_PH_TMO:   prdata = {16'd0, ph_tmo_reg};
            REG_LONG_TMO: prdata = {8'd0, long_tmo_reg};
            REG_DROP:     prdata = {24'd0, drop_reg};
            REG_RST_HOLD: prdata = {16'd0, rst_hold_reg};
            REG_SETTLE:   prdata = {24'd0, settle_reg};
            default:      prdata = 32'd0;
        endcase
    end

    assign s_ready = (cnt_reg <= 3'd1);
    assign acc     = s_valid & s_ready;
    assign m_valid = (cnt_reg != 3'd0);
    assign pop     = m_valid & m_ready;
    assign m_data  = fifo_reg[rp_reg];

    assign busy   = s_data.bus_busy;
    assign q      = {s_data.bus_input, s_data.bus_control, s_data.bus_req, s_data.bus_busy};
    assign pc_inc = pc_reg + 24'd1;
    assign bc_inc = bc_reg + BCW'(1);

    assign we    = acc && s_data.operation == OP_LOAD &&
                   32'(s_data.load_index) < 32'(SECTOR_BYTES);
    assign waddr = AW'(s_data.load_index);
    assign raddr = bc_next[AW-1:0];

    always_ff @(posedge aclk) begin
        if (we) begin
            store[waddr] <= s_data.load_byte;
        end
        if (we && waddr == raddr) begin
            rdata_reg <= s_data.load_byte;
        end else begin
            rdata_reg <= store[raddr];
        end
    end

    always_comb begin
        step_next = step_reg;
        pc_next   = pc_reg;
        bc_next   = bc_reg;
        ac_next   = ac_reg;
        init_next = init_reg;
        lba_next  = lba_reg;
        cap_next  = cap_reg;
        dev_next  = dev_reg;
        nres_c    = 2'd0;
        fail_c    = 1'b0;
        fail_err  = E_OK;
        fail_msg  = 8'd0;
        for (int k = 0; k < 3; k++) begin
            res_c[k] = '0;
        end
        if (acc && s_data.operation == OP_START && step_reg == S_IDLE) begin
            if (s_data.command == CMD_INIT) begin
                if (dev_reg) begin
                    res_c[0] = mk(K_DONE, 8'd0, ACT_RELEASE, 9'd0, E_OK, 8'd0, 8'd0);
                    nres_c = 2'd1;
                end else begin
                    init_next = 3'd1;
                    ac_next   = AC_TUR;
                    cap_next  = 8'd0;
                    res_c[0]  = mk(K_CTRL, 8'd0, ACT_RESET, 9'd0, E_OK, 8'd0, 8'd0);
                    nres_c    = 2'd1;
                    step_next = S_RST_HOLD;
                    pc_next   = 24'd0;
                end
            end else if (s_data.command == CMD_SENSE) begin
                ac_next   = AC_SENSE;
                cap_next  = 8'd0;
                bc_next   = '0;
                step_next = S_BUSY_CLR;
                pc_next   = 24'd0;
            end else if (s_data.command == CMD_WRITE && !wren_reg) begin
                res_c[0] = mk(K_DONE, 8'd0, ACT_RELEASE, 9'd0, E_RO, 8'd0, 8'd0);
                nres_c   = 2'd1;
            end else if (!dev_reg) begin
                res_c[0] = mk(K_DONE, 8'd0, ACT_RELEASE, 9'd0, E_NODEV, 8'd0, 8'd0);
                nres_c   = 2'd1;
            end else if (s_data.block_address > LBA_LIMIT) begin
                res_c[0] = mk(K_CTRL, 8'd0, ACT_RELEASE, 9'd0, E_OK, 8'd0, 8'd0);
                res_c[1] = mk(K_DONE, 8'd0, ACT_RELEASE, 9'd0, E_INVAL, 8'd0, 8'd0);
                nres_c   = 2'd2;
            end else begin
                lba_next  = s_data.block_address[20:0];
                ac_next   = (s_data.command == CMD_READ) ? AC_READ : AC_WRITE;
                cap_next  = 8'd0;
                bc_next   = '0;
                step_next = S_BUSY_CLR;
                pc_next   = 24'd0;
            end
        end else if (acc && s_data.operation == OP_POLL) begin
            unique case (step_reg)
                S_RST_HOLD: begin
                    pc_next = pc_inc;
                    if (pc_inc >= 24'(rst_hold_reg)) begin
                        res_c[0] = mk(K_CTRL, 8'd0, ACT_RELEASE, 9'd0, E_OK, 8'd0, 8'd0);
                        nres_c    = 2'd1;
                        step_next = S_RST_GAP;
                        pc_next   = 24'd0;
                    end
                end
                S_RST_GAP: begin
                    pc_next = pc_inc;
                    if (pc_inc >= 24'(rst_hold_reg)) begin
                        cap_next  = 8'd0;
                        bc_next   = '0;
                        step_next = S_BUSY_CLR;
                        pc_next   = 24'd0;
                    end
                end
                S_BUSY_CLR: begin
                    if (!busy) begin
                        res_c[0] = mk(K_DATA, 8'd1 << target_reg, ACT_RELEASE, 9'd0,
                                      E_OK, 8'd0, 8'd0);
                        nres_c  = 2'd1;
                        pc_next = 24'd0;
                        if (settle_reg == 8'd0) begin
                            res_c[1] = mk(K_CTRL, 8'd0, ACT_SELECT, 9'd0, E_OK, 8'd0, 8'd0);
                            nres_c    = 2'd2;
                            step_next = S_BUSY_SET;
                        end else begin
                            step_next = S_SETTLE;
                        end
                    end else begin
                        pc_next = pc_inc;
                        if (pc_inc >= 24'(ph_tmo_reg)) begin
                            fail_c   = 1'b1;
                            fail_err = E_TIME;
                        end
                    end
                end
                S_SETTLE: begin
                    pc_next = pc_inc;
                    if (pc_inc >= 24'(settle_reg)) begin
                        res_c[0] = mk(K_CTRL, 8'd0, ACT_SELECT, 9'd0, E_OK, 8'd0, 8'd0);
                        nres_c    = 2'd1;
                        step_next = S_BUSY_SET;
                        pc_next   = 24'd0;
                    end
                end
                S_BUSY_SET: begin
                    if (busy) begin
                        res_c[0] = mk(K_CTRL, 8'd0, ACT_RELEASE, 9'd0, E_OK, 8'd0, 8'd0);
                        nres_c    = 2'd1;
                        step_next = S_SEL_REQ;
                        pc_next   = 24'd0;
                    end else begin
                        pc_next = pc_inc;
                        if (pc_inc >= 24'(sel_tmo_reg)) begin
                            fail_c   = 1'b1;
                            fail_err = E_TIME;
                        end
                    end
                end
                S_SEL_REQ, S_CDB_REQ: begin
                    if (!busy) begin
                        fail_c   = 1'b1;
                        fail_err = E_IO;
                    end else if (q == 4'b0111) begin
                        pc_next = 24'd0;
                        if (step_reg == S_SEL_REQ) begin
                            bc_next   = '0;
                            step_next = S_CDB_REQ;
                        end else begin
                            res_c[0] = mk(K_DATA, cdb_byte(ac_reg, lba_reg, bc_reg[2:0]),
                                          ACT_RELEASE, 9'd0, E_OK, 8'd0, 8'd0);
                            nres_c    = 2'd1;
                            step_next = S_CDB_DROP;
                        end
                    end else begin
                        pc_next = pc_inc;
                        if (pc_inc >= 24'(ph_tmo_reg)) begin
                            fail_c   = 1'b1;
                            fail_err = E_TIME;
                        end
                    end
                end
                S_CDB_DROP, S_DOUT_DROP: begin
                    if (s_data.bus_req) begin
                        pc_next = pc_inc;
                    end
                    if (!s_data.bus_req || pc_inc >= 24'(drop_reg)) begin
                        bc_next = bc_inc;
                        pc_next = 24'd0;
                        if (step_reg == S_CDB_DROP) begin
                            if (bc_inc < BCW'(6)) begin
                                step_next = S_CDB_REQ;
                            end else begin
                                bc_next = '0;
                                if (ac_reg == AC_READ || ac_reg == AC_SENSE) begin
                                    step_next = S_DIN_PHASE;
                                end else if (ac_reg == AC_WRITE) begin
                                    step_next = S_DOUT_PHASE;
                                end else begin
                                    step_next = S_STATUS;
                                end
                            end
                        end else begin
                            step_next = (bc_inc >= BCW'(SECTOR_BYTES)) ? S_STATUS
                                                                        : S_DOUT_REQ;
                        end
                    end
                end
                S_DIN_PHASE, S_DOUT_PHASE: begin
                    if (!busy) begin
                        fail_c   = 1'b1;
                        fail_err = E_IO;
                    end else if (q[0] && !q[2] &&
                                 (q[3] == (step_reg == S_DIN_PHASE))) begin
                        step_next = (step_reg == S_DIN_PHASE) ? S_DIN_REQ : S_DOUT_REQ;
                        pc_next   = 24'd0;
                    end else begin
                        pc_next = pc_inc;
                        if (pc_inc >= long_tmo_reg) begin
                            fail_c   = 1'b1;
                            fail_err = E_TIME;
                        end
                    end
                end
                S_DIN_REQ, S_DOUT_REQ: begin
                    if (!busy) begin
                        fail_c   = 1'b1;
                        fail_err = E_IO;
                    end else if (q == ((step_reg == S_DIN_REQ) ? 4'b1011 : 4'b0011)) begin
                        pc_next = 24'd0;
                        if (step_reg == S_DIN_REQ) begin
                            res_c[0] = mk((ac_reg == AC_SENSE) ? K_SENSE : K_SECT,
                                          s_data.bus_data, ACT_RELEASE, 9'(bc_reg),
                                          E_OK, 8'd0, 8'd0);
                            nres_c  = 2'd1;
                            bc_next = bc_inc;
                            if (bc_inc >= ((ac_reg == AC_SENSE) ? BCW'(4)
                                                                 : BCW'(SECTOR_BYTES))) begin
                                step_next = S_STATUS;
                            end else begin
                                step_next = S_DIN_REQ;
                            end
                        end else begin
                            res_c[0] = mk(K_DATA, rdata_reg, ACT_RELEASE, 9'd0,
                                          E_OK, 8'd0, 8'd0);
                            nres_c    = 2'd1;
                            step_next = S_DOUT_DROP;
                        end
                    end else begin
                        pc_next = pc_inc;
                        if (pc_inc >= ((bc_reg == '0) ? long_tmo_reg : 24'(ph_tmo_reg))) begin
                            fail_c   = 1'b1;
                            fail_err = E_TIME;
                        end
                    end
                end
                S_STATUS: begin
                    if (!busy) begin
                        fail_c   = 1'b1;
                        fail_err = E_IO;
                    end else if (q == 4'b1111) begin
                        cap_next  = s_data.bus_data;
                        step_next = S_MESSAGE;
                        pc_next   = 24'd0;
                    end else begin
                        pc_next = pc_inc;
                        if (pc_inc >= long_tmo_reg) begin
                            fail_c   = 1'b1;
                            fail_err = E_TIME;
                        end
                    end
                end
                S_MESSAGE: begin
                    if (!busy) begin
                        fail_c   = 1'b1;
                        fail_err = E_IO;
                    end else if (q == 4'b1111 && s_data.bus_msg) begin
                        if (cap_reg != 8'd0 || s_data.bus_data != 8'd0) begin
                            fail_c   = 1'b1;
                            fail_err = E_IO;
                            fail_msg = s_data.bus_data;
                        end else begin
                            if (init_reg >= 3'd1 && init_reg <= 3'd3) begin
                                init_next = init_reg + 3'd1;
                                ac_next   = init_reg;
                                cap_next  = 8'd0;
                                bc_next   = '0;
                                step_next = S_BUSY_CLR;
                                pc_next   = 24'd0;
                            end else begin
                                if (init_reg != 3'd0) begin
                                    dev_next = 1'b1;
                                end
                                init_next = 3'd0;
                                step_next = S_IDLE;
                            end
                            if (init_reg == 3'd0 || init_reg == 3'd4) begin
                                res_c[0] = mk(K_DONE, 8'd0, ACT_RELEASE, 9'd0, E_OK,
                                              cap_reg, 8'd0);
                                nres_c = 2'd1;
                            end
                        end
                    end else begin
                        pc_next = pc_inc;
                        if (pc_inc >= long_tmo_reg) begin
                            fail_c   = 1'b1;
                            fail_err = E_TIME;
                        end
                    end
                end
                default: ;
            endcase
            if (fail_c) begin
                res_c[0] = mk(K_CTRL, 8'd0, ACT_RELEASE, 9'd0, E_OK, 8'd0, 8'd0);
                res_c[1] = mk(K_DONE, 8'd0, ACT_RELEASE, 9'd0, fail_err, cap_reg, fail_msg);
                nres_c   = 2'd2;
                if (init_reg != 3'd0) begin
                    dev_next = 1'b0;
                end
                init_next = 3'd0;
                step_next = S_IDLE;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            res_f[k] = res_c[k];
            res_f[k].last_of_run  = (2'(k) == nres_c - 2'd1);
            res_f[k].device_ready = dev_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= S_IDLE;
            pc_reg   <= 24'd0;
            bc_reg   <= '0;
            ac_reg   <= 3'd0;
            init_reg <= 3'd0;
            lba_reg  <= 21'd0;
            cap_reg  <= 8'd0;
            dev_reg  <= 1'b0;
        end else begin
            step_reg <= step_next;
            pc_reg   <= pc_next;
            bc_reg   <= bc_next;
            ac_reg   <= ac_next;
            init_reg <= init_next;
            lba_reg  <= lba_next;
            cap_reg  <= cap_next;
            dev_reg  <= dev_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < nres_c) begin
                fifo_reg[wp_reg + 2'(k)] <= res_f[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 2'd0;
            rp_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end else begin
            wp_reg  <= wp_reg + nres_c;
            rp_reg  <= rp_reg + {1'b0, pop};
            cnt_reg <= cnt_reg + {1'b0, nres_c} - {2'b00, pop};
        end
    end

`include "sasi_initiator_sector_sequencer_assert.svh"

    `SISS_ASSERT_IMP(a_queue_bound, aclk, aresetn, 1'b1, cnt_reg <= 3'd4, "Result queue overflow.")
    `SISS_ASSERT_IMP(a_no_push_idle, aclk, aresetn, !acc, nres_c == 2'd0, "Result without a transaction.")
    `SISS_ASSERT_IMP(a_idle_no_init, aclk, aresetn, step_reg == S_IDLE, init_reg == 3'd0, "Initialise step left while idle.")
    `SISS_ASSERT_NEXT(a_ready_after_drain, aclk, aresetn, cnt_reg == 3'd1 && pop && nres_c == 2'd0, s_ready, "Input stalled on an empty queue.")

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the SASI initiator sector sequencer.
// Depends on siss_pkg and the sequencer RTL; it predicts every result item from its own model.
`timescale 1ns / 1ps

module testbench;
    import siss_pkg::*;

    localparam int SECTOR = 512;
    localparam int PRELOAD = 32;
    localparam int IDLE_LIMIT = 4000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_t         s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_t        m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sasi_initiator_sector_sequencer uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 aclk = ~aclk;

    // Sequencer model state and its copy of the registers.
    step_t       seq;
    logic [23:0] polls;
    int unsigned nbytes;
    logic [2:0]  cmd_cur;
    int unsigned init_phase;
    logic [20:0] lba_held;
    logic [7:0]  status_held;
    bit          ready_flag;
    logic [7:0]  sector_mem [0:SECTOR-1];
    logic [2:0]  c_target;
    bit          c_wren;
    logic [15:0] c_sel, c_phase, c_hold;
    logic [23:0] c_long;
    logic [7:0]  c_drop, c_settle;

    out_t run_results[$];
    out_t expected_results[$];
    int   errors = 0;
    int   burst_left = 0;
    int   quiet_cycles = 0;
    int   stall_left = 0;
    int   stall_mode = 0;

    function automatic void add(logic [2:0] k, logic [7:0] v, logic [1:0] a, logic [8:0] i,
                                logic [2:0] e, logic [7:0] st, logic [7:0] msg);
        out_t r;
        r = '0;
        r.result_kind = k;
        r.bus_value = v;
        r.control_action = a;
        r.byte_index = i;
        r.error_code = e;
        r.cmd_status = st;
        r.cmd_message = msg;
        run_results.push_back(r);
    endfunction

    function automatic bit timed(int unsigned budget);
        polls = polls + 24'd1;
        return {8'd0, polls} >= budget;
    endfunction

    function automatic void enter(step_t s);
        seq = s;
        polls = '0;
    endfunction

    function automatic void open_select();
        status_held = '0;
        nbytes = 0;
        enter(S_BUSY_CLR);
    endfunction

    function automatic void abort(logic [2:0] e, logic [7:0] msg);
        add(K_CTRL, 8'd0, ACT_RELEASE, 9'd0, E_OK, 8'd0, 8'd0);
        add(K_DONE, 8'd0, ACT_RELEASE, 9'd0, e, status_held, msg);
        if (init_phase != 0) ready_flag = 1'b0;
        init_phase = 0;
        seq = S_IDLE;
    endfunction

    function automatic logic [7:0] command_byte(int unsigned i);
        bit rw;
        rw = (cmd_cur == AC_READ) || (cmd_cur == AC_WRITE);
        if (i == 0) begin
            case (cmd_cur)
                AC_RAM:   return 8'hE0;
                AC_CTL:   return 8'hE4;
                AC_SENSE: return 8'h03;
                AC_READ:  return 8'h08;
                AC_WRITE: return 8'h0A;
                default:  return 8'h00;
            endcase
        end
        if (!rw) return 8'h00;
        case (i)
            1:       return {3'b000, lba_held[20:16]};
            2:       return lba_held[15:8];
            3:       return lba_held[7:0];
            4:       return 8'h01;
            default: return 8'h00;
        endcase
    endfunction

    function automatic void raise_select();
        add(K_CTRL, 8'd0, ACT_SELECT, 9'd0, E_OK, 8'd0, 8'd0);
        enter(S_BUSY_SET);
    endfunction

    function automatic void complete_ok();
        if (init_phase >= 1 && init_phase <= 3) begin
            init_phase++;
            cmd_cur = 3'(init_phase - 1);
            open_select();
            return;
        end
        if (init_phase != 0) ready_flag = 1'b1;
        init_phase = 0;
        seq = S_IDLE;
    endfunction

    // Signal bits: 0 busy, 1 request, 2 control, 3 input, 4 message.
    function automatic void model_poll(logic [4:0] s, logic [7:0] d);
        bit busy, rd, tell;
        logic [3:0] q;
        logic [7:0] st;
        int unsigned total;
        busy = s[0];
        q = s[3:0];
        case (seq)
            S_RST_HOLD: if (timed(c_hold)) begin
                add(K_CTRL, 8'd0, ACT_RELEASE, 9'd0, E_OK, 8'd0, 8'd0);
                enter(S_RST_GAP);
            end
            S_RST_GAP: if (timed(c_hold)) open_select();
            S_BUSY_CLR: begin
                if (!busy) begin
                    add(K_DATA, 8'd1 << c_target, ACT_RELEASE, 9'd0, E_OK, 8'd0, 8'd0);
                    if (c_settle == 0) raise_select(); else enter(S_SETTLE);
                end else if (timed(c_phase)) abort(E_TIME, 8'd0);
            end
            S_SETTLE: if (timed(c_settle)) raise_select();
            S_BUSY_SET: begin
                if (busy) begin
                    add(K_CTRL, 8'd0, ACT_RELEASE, 9'd0, E_OK, 8'd0, 8'd0);
                    enter(S_SEL_REQ);
                end else if (timed(c_sel)) abort(E_TIME, 8'd0);
            end
            S_SEL_REQ, S_CDB_REQ: begin
                if (!busy) abort(E_IO, 8'd0);
                else if (q == 4'b0111) begin
                    if (seq == S_SEL_REQ) begin
                        nbytes = 0;
                        enter(S_CDB_REQ);
                    end else begin
                        add(K_DATA, command_byte(nbytes), ACT_RELEASE, 9'd0, E_OK, 8'd0, 8'd0);
                        enter(S_CDB_DROP);
                    end
                end else if (timed(c_phase)) abort(E_TIME, 8'd0);
            end
            S_CDB_DROP, S_DOUT_DROP: begin
                if (!s[1] || timed(c_drop)) begin
                    nbytes++;
                    if (seq == S_CDB_DROP) begin
                        if (nbytes < 6) enter(S_CDB_REQ);
                        else begin
                            nbytes = 0;
                            if (cmd_cur == AC_READ || cmd_cur == AC_SENSE) enter(S_DIN_PHASE);
                            else if (cmd_cur == AC_WRITE) enter(S_DOUT_PHASE);
                            else enter(S_STATUS);
                        end
                    end else enter(nbytes >= SECTOR ? S_STATUS : S_DOUT_REQ);
                end
            end
            S_DIN_PHASE, S_DOUT_PHASE: begin
                rd = (seq == S_DIN_PHASE);
                if (!busy) abort(E_IO, 8'd0);
                else if ({s[3], s[2], s[0]} == (rd ? 3'b101 : 3'b001))
                    enter(rd ? S_DIN_REQ : S_DOUT_REQ);
                else if (timed(c_long)) abort(E_TIME, 8'd0);
            end
            S_DIN_REQ, S_DOUT_REQ: begin
                rd = (seq == S_DIN_REQ);
                if (!busy) abort(E_IO, 8'd0);
                else if (q == (rd ? 4'b1011 : 4'b0011)) begin
                    if (rd) begin
                        total = (cmd_cur == AC_SENSE) ? 4 : SECTOR;
                        add(cmd_cur == AC_SENSE ? K_SENSE : K_SECT, d, ACT_RELEASE,
                            9'(nbytes), E_OK, 8'd0, 8'd0);
                        nbytes++;
                        enter(nbytes >= total ? S_STATUS : S_DIN_REQ);
                    end else begin
                        add(K_DATA, sector_mem[nbytes], ACT_RELEASE, 9'd0, E_OK, 8'd0, 8'd0);
                        enter(S_DOUT_DROP);
                    end
                end else if (timed(nbytes == 0 ? c_long : c_phase)) abort(E_TIME, 8'd0);
            end
            S_STATUS: begin
                if (!busy) abort(E_IO, 8'd0);
                else if (q == 4'b1111) begin
                    status_held = d;
                    enter(S_MESSAGE);
                end else if (timed(c_long)) abort(E_TIME, 8'd0);
            end
            S_MESSAGE: begin
                if (!busy) abort(E_IO, 8'd0);
                else if (s == 5'b11111) begin
                    if (status_held != 0 || d != 0) abort(E_IO, d);
                    else begin
                        st = status_held;
                        tell = (init_phase == 0) || (init_phase == 4);
                        complete_ok();
                        if (tell) add(K_DONE, 8'd0, ACT_RELEASE, 9'd0, E_OK, st, 8'd0);
                    end
                end else if (timed(c_long)) abort(E_TIME, 8'd0);
            end
            default: ;
        endcase
    endfunction

    function automatic void model_start(logic [1:0] cmd, logic [31:0] lba);
        if (cmd == CMD_INIT) begin
            if (ready_flag) begin
                add(K_DONE, 8'd0, ACT_RELEASE, 9'd0, E_OK, 8'd0, 8'd0);
                return;
            end
            init_phase = 1;
            cmd_cur = AC_TUR;
            status_held = '0;
            add(K_CTRL, 8'd0, ACT_RESET, 9'd0, E_OK, 8'd0, 8'd0);
            enter(S_RST_HOLD);
            return;
        end
        if (cmd == CMD_SENSE) begin
            cmd_cur = AC_SENSE;
            open_select();
            return;
        end
        if (cmd == CMD_WRITE && !c_wren) begin
            add(K_DONE, 8'd0, ACT_RELEASE, 9'd0, E_RO, 8'd0, 8'd0);
            return;
        end
        if (!ready_flag) begin
            add(K_DONE, 8'd0, ACT_RELEASE, 9'd0, E_NODEV, 8'd0, 8'd0);
            return;
        end
        if (lba > LBA_LIMIT) begin
            add(K_CTRL, 8'd0, ACT_RELEASE, 9'd0, E_OK, 8'd0, 8'd0);
            add(K_DONE, 8'd0, ACT_RELEASE, 9'd0, E_INVAL, 8'd0, 8'd0);
            return;
        end
        lba_held = lba[20:0];
        cmd_cur = (cmd == CMD_READ) ? AC_READ : AC_WRITE;
        open_select();
    endfunction

    function automatic void predict(in_t it);
        run_results.delete();
        case (it.operation)
            OP_LOAD:  sector_mem[it.load_index] = it.load_byte;
            OP_START: if (seq == S_IDLE) model_start(it.command, it.block_address);
            OP_POLL:  model_poll({it.bus_msg, it.bus_input, it.bus_control, it.bus_req,
                                  it.bus_busy}, it.bus_data);
            default: ;
        endcase
        foreach (run_results[k]) begin
            run_results[k].last_of_run = (k == run_results.size() - 1);
            run_results[k].device_ready = ready_flag;
            expected_results.push_back(run_results[k]);
        end
    endfunction

    task automatic send_item(input in_t it);
        if (burst_left == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        s_data = it;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict(it);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    function automatic in_t filler();
        in_t it;
        it.operation = OP_POLL;
        it.command = 2'($urandom);
        it.block_address = $urandom;
        it.load_byte = 8'($urandom);
        it.load_index = 9'($urandom);
        {it.bus_msg, it.bus_input, it.bus_control, it.bus_req, it.bus_busy} = 5'($urandom);
        it.bus_data = 8'($urandom);
        return it;
    endfunction

    task automatic send_poll(input logic [4:0] s, input logic [7:0] d);
        in_t it;
        it = filler();
        {it.bus_msg, it.bus_input, it.bus_control, it.bus_req, it.bus_busy} = s;
        it.bus_data = d;
        send_item(it);
    endtask

    task automatic send_start(input logic [1:0] cmd, input logic [31:0] lba);
        in_t it;
        it = filler();
        it.operation = OP_START;
        it.command = cmd;
        it.block_address = lba;
        send_item(it);
    endtask

    task automatic send_load(input logic [8:0] idx, input logic [7:0] b);
        in_t it;
        it = filler();
        it.operation = OP_LOAD;
        it.load_index = idx;
        it.load_byte = b;
        send_item(it);
    endtask

    // One poll as a well-behaved target would answer it; noise_div > 0 mixes in garbage.
    task automatic bus_tick(input int noise_div);
        logic [4:0] r, s;
        logic [7:0] d;
        r = 5'($urandom);
        d = 8'($urandom);
        case (seq)
            S_BUSY_CLR:   s = r & 5'b11110;
            S_BUSY_SET:   s = r | 5'b00001;
            S_SEL_REQ,
            S_CDB_REQ:    s = {r[4], 4'b0111};
            S_CDB_DROP,
            S_DOUT_DROP:  s = (r & 5'b11101) | 5'b00001;
            S_DIN_PHASE:  s = {r[4], 2'b10, r[1], 1'b1};
            S_DOUT_PHASE: s = {r[4], 2'b00, r[1], 1'b1};
            S_DIN_REQ:    s = {r[4], 4'b1011};
            S_DOUT_REQ:   s = {r[4], 4'b0011};
            S_STATUS:     begin s = {r[4], 4'b1111}; d = 8'd0; end
            S_MESSAGE:    begin s = 5'b11111; d = 8'd0; end
            default:      s = r;
        endcase
        if (noise_div != 0 && $urandom_range(0, noise_div - 1) == 0) begin
            s = 5'($urandom);
            d = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'd0;
        end
        send_poll(s, d);
    endtask

    task automatic advance_to(input step_t target);
        while (seq != target) bus_tick(0);
    endtask

    // A dead bus ends any running command quickly.
    task automatic abort_run();
        while (seq != S_IDLE) send_poll(5'b00000, 8'd0);
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = v;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        case (idx)
            REG_TARGET:   c_target = v[2:0];
            REG_WREN:     c_wren = v[0];
            REG_SEL_TMO:  c_sel = v[15:0];
            REG_PH_TMO:   c_phase = v[15:0];
            REG_LONG_TMO: c_long = v[23:0];
            REG_DROP:     c_drop = v[7:0];
            REG_RST_HOLD: c_hold = v[15:0];
            REG_SETTLE:   c_settle = v[7:0];
            default: ;
        endcase
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic write_all(input logic [2:0] tgt, input bit wr, input logic [15:0] sel,
                             input logic [15:0] ph, input logic [23:0] lng,
                             input logic [7:0] drp, input logic [15:0] hold,
                             input logic [7:0] settle);
        write_reg(REG_TARGET, 32'(tgt));
        write_reg(REG_WREN, 32'(wr));
        write_reg(REG_SEL_TMO, 32'(sel));
        write_reg(REG_PH_TMO, 32'(ph));
        write_reg(REG_LONG_TMO, 32'(lng));
        write_reg(REG_DROP, 32'(drp));
        write_reg(REG_RST_HOLD, 32'(hold));
        write_reg(REG_SETTLE, 32'(settle));
    endtask

    task automatic test_refused_commands();
        write_all(3'd5, 1'b0, 16'd8, 16'd8, 24'd12, 8'd3, 16'd2, 8'd1);
        send_poll(5'b11111, 8'hFF);
        send_start(CMD_READ, 32'd5);
        send_start(CMD_WRITE, 32'd5);
        begin
            in_t it;
            it = filler();
            it.operation = OP_UNUSED;
            send_item(it);
        end
        wait_drained();
    endtask

    task automatic test_sector_load();
        for (int i = 0; i < PRELOAD; i++) send_load(9'(i), 8'($urandom));
        wait_drained();
    endtask

    task automatic test_init_failure();
        send_start(CMD_INIT, 32'd0);
        advance_to(S_SEL_REQ);
        send_poll(5'b00110, 8'd0);
        wait_drained();
    endtask

    task automatic test_initialize();
        write_all(3'd2, 1'b0, 16'd4, 16'd4, 24'd8, 8'd2, 16'd1, 8'd0);
        if (!ready_flag) begin
            send_start(CMD_INIT, 32'd0);
            advance_to(S_IDLE);
        end
        send_start(CMD_INIT, 32'd0);
        send_poll(5'b00000, 8'd0);
        wait_drained();
    endtask

    task automatic test_address_check();
        write_reg(REG_WREN, 32'd1);
        send_start(CMD_READ, 32'h0020_0000);
        send_start(CMD_WRITE, 32'hFFFF_FFFF);
        wait_drained();
    endtask

    task automatic test_start_while_busy();
        send_start(CMD_SENSE, 32'd0);
        send_start(CMD_READ, 32'd1);
        advance_to(S_IDLE);
        wait_drained();
    endtask

    task automatic test_bus_faults();
        send_start(CMD_SENSE, 32'd0);
        advance_to(S_SEL_REQ);
        send_poll(5'b01110, 8'd0);
        send_start(CMD_SENSE, 32'd0);
        advance_to(S_BUSY_SET);
        while (seq != S_IDLE) send_poll(5'b11110, 8'($urandom));
        send_start(CMD_SENSE, 32'd0);
        advance_to(S_STATUS);
        send_poll(5'b01111, 8'h02);
        advance_to(S_IDLE);
        send_start(CMD_SENSE, 32'd0);
        advance_to(S_MESSAGE);
        send_poll(5'b11111, 8'h80);
        send_start(CMD_READ, 32'h0012_3456);
        advance_to(S_CDB_DROP);
        while (seq == S_CDB_DROP) send_poll(5'b00011, 8'd0);
        abort_run();
        wait_drained();
    endtask

    task automatic test_register_extremes();
        write_all(3'd7, 1'b1, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 8'hFF, 16'hFFFF, 8'd0);
        send_start(CMD_INIT, 32'd0);
        send_start(CMD_WRITE, LBA_LIMIT);
        advance_to(S_DOUT_REQ);
        repeat (8) bus_tick(0);
        abort_run();
        send_start(CMD_READ, 32'h000A_AAAA);
        advance_to(S_DIN_REQ);
        repeat (6) bus_tick(0);
        abort_run();
        wait_drained();
        write_all(3'd0, 1'b0, 16'd1, 16'd1, 24'd1, 8'd1, 16'd1, 8'd0);
        send_start(CMD_SENSE, 32'd0);
        advance_to(S_IDLE);
        send_start(CMD_WRITE, 32'd0);
        send_start(CMD_SENSE, 32'd0);
        send_poll(5'b00001, 8'd0);
        send_poll(5'b00001, 8'd0);
        advance_to(S_IDLE);
        wait_drained();
    endtask

    task automatic random_phase(input int n);
        int noise, r;
        logic [31:0] lba;
        logic [1:0] cmd;
        write_all(3'($urandom), 1'($urandom), 16'($urandom_range(1, 20)),
                  16'($urandom_range(1, 20)), 24'($urandom_range(1, 40)),
                  8'($urandom_range(1, 8)), 16'($urandom_range(1, 6)),
                  8'($urandom_range(0, 4)));
        noise = 0;
        for (int i = 0; i < n; i++) begin
            if (seq == S_IDLE) begin
                if ($urandom_range(0, 9) == 0) wait_drained();
                r = $urandom_range(0, 99);
                if (r < 8) send_load(9'($urandom), 8'($urandom));
                else if (r < 12) send_poll(5'($urandom), 8'($urandom));
                else if (r < 15) begin
                    in_t it;
                    it = filler();
                    it.operation = OP_UNUSED;
                    send_item(it);
                end else begin
                    r = $urandom_range(0, 99);
                    cmd = (r < 20) ? CMD_INIT : (r < 40) ? CMD_READ
                        : (r < 55) ? CMD_WRITE : CMD_SENSE;
                    r = $urandom_range(0, 9);
                    lba = (r < 2) ? $urandom : (r == 2) ? LBA_LIMIT
                        : (r == 3) ? LBA_LIMIT + 1 : 32'($urandom_range(0, 32'h1F_FFFF));
                    noise = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(8, 30);
                    send_start(cmd, lba);
                end
            end else if ($urandom_range(0, 39) == 0) begin
                send_start(2'($urandom), $urandom);
            end else bus_tick(noise);
        end
        abort_run();
        wait_drained();
    endtask

    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        case (stall_mode)
            0: m_ready = 1'b1;
            1: m_ready = ~m_ready;
            2: m_ready = ($urandom_range(0, 3) != 0);
            default: m_ready = ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic check_field(input string name, input int unsigned e, input int unsigned a);
        if (e != a) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, e, a);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_data);
                errors++;
            end else begin
                e = expected_results.pop_front();
                check_field("result_kind", e.result_kind, m_data.result_kind);
                check_field("bus_value", e.bus_value, m_data.bus_value);
                check_field("control_action", e.control_action, m_data.control_action);
                check_field("byte_index", e.byte_index, m_data.byte_index);
                check_field("last_of_run", e.last_of_run, m_data.last_of_run);
                check_field("error_code", e.error_code, m_data.error_code);
                check_field("cmd_status", e.cmd_status, m_data.cmd_status);
                check_field("cmd_message", e.cmd_message, m_data.cmd_message);
                check_field("device_ready", e.device_ready, m_data.device_ready);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        seq = S_IDLE;
        polls = '0;
        nbytes = 0;
        cmd_cur = AC_TUR;
        init_phase = 0;
        lba_held = '0;
        status_held = '0;
        ready_flag = 1'b0;
        c_target = 3'd0;
        c_wren = 1'b0;
        c_sel = 16'd1000;
        c_phase = 16'd10000;
        c_long = 24'd16776960;
        c_drop = 8'd100;
        c_hold = 16'd10000;
        c_settle = 8'd10;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_refused_commands();
        test_sector_load();
        test_init_failure();
        random_phase(40);
        test_initialize();
        test_address_check();
        test_start_while_busy();
        test_bus_faults();
        test_register_extremes();
        random_phase(30);
        random_phase(30);
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
